// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the flash erase and program sequencer.
// Needs signals clk and arst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Implication checked in the same cycle.
`define ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/feps_pkg.sv
// Package of the flash erase and program sequencer: phase type, page sizes,
// register indexes and command flag layout. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package feps_pkg;

	typedef enum logic [2:0] {
		PH_IDLE       = 3'd0,
		PH_ERASE_WAIT = 3'd1,
		PH_ERASE_CMD  = 3'd2,
		PH_WRITE_WAIT = 3'd3,
		PH_WRITE_CMD  = 3'd4
	} phase_t;

	// item kind carried on s_tuser
	localparam logic ACT_ERASE = 1'b0;
	localparam logic ACT_WRITE = 1'b1;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDR     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BANK_ZERO_END = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DUAL_BANK     = 2'd2;

	localparam logic [31:0] BASE_ADDR_RST     = 32'h0800_0000;
	localparam logic [31:0] BANK_ZERO_END_RST = 32'h0808_0000;

	// page sizes and word size, in bytes
	localparam logic [23:0] PAGE_BANK_ZERO = 24'd2048;
	localparam logic [23:0] PAGE_BANK_ONE  = 24'd4096;
	localparam logic [23:0] WORD_BYTES     = 24'd4;

	localparam int unsigned S_TDATA_W = 88;
	localparam int unsigned M_TDATA_W = 72;

	// command flags, use_bank_one in bit 0
	typedef struct packed {
		logic program_word;
		logic mirror_address;
		logic start_page_erase;
		logic clear_program_enable;
		logic clear_erase_enable;
		logic do_lock;
		logic do_unlock;
		logic use_bank_one;
	} cmd_flags_t;

endpackage

`default_nettype wire

// File: rtl/flash_erase_program_sequencer_top.sv
// Top level of the flash erase and program sequencer: input stage, step logic,
// result stage and configuration registers. Depends on feps_pkg, assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

// Flash erase / program sequencer. Each input item is one step of an erase
// (s_tuser 0) or write (s_tuser 1) operation and yields exactly one result item
// of command flags for the flash controller. From idle a step latches the start
// address (base address + offset), the byte count and the bank (bank one when
// dual_bank is set and the address is at or above bank_zero_end) and asks for
// unlock; the operation then alternates wait steps (hold while bank_busy) and
// command steps (one page erase of 2 KiB / 4 KiB, or one 32-bit word program).
// A wait step with nothing left relocks and raises done (m_tlast). A step of
// the other kind aborts to idle without relocking. Timing: one item per cycle
// sustained while m_tready does not stall the result; an accepted item passes
// through the input register, then the result register fed by the combinational
// step logic (a 32-bit add feeding a compare and a 24-bit subtract/compare),
// before its result shows on m_tvalid. A stalled result holds the input
// register, which still takes a new item in the cycle the result drains.
// Configuration is only to be written while the block is idle.
module flash_erase_program_sequencer_top (
	input  wire                              clk,
	input  wire                              arst_n,
	// configuration write port
	input  wire                              cfg_wr_en,
	input  wire [feps_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire [31:0]                       cfg_data,
	// input stream
	input  wire                              s_tvalid,
	output logic                             s_tready,
	// offset[23:0], byte_count[47:24], data_word[79:48], bank_busy[80],
	// security_on[81], zero pad[87:82]
	input  wire [feps_pkg::S_TDATA_W-1:0]    s_tdata,
	// action[0]
	input  wire                              s_tuser,
	// result stream
	output logic                             m_tvalid,
	input  wire                              m_tready,
	// use_bank_one[0], do_unlock[1], do_lock[2], clear_erase_enable[3],
	// clear_program_enable[4], start_page_erase[5], mirror_address[6],
	// program_word[7], target_address[39:8], write_data[71:40]
	output logic [feps_pkg::M_TDATA_W-1:0]   m_tdata,
	// done_res
	output logic                             m_tlast
);
	import feps_pkg::*;

	// configuration
	logic [31:0] base_addr_q;
	logic [31:0] bank_zero_end_q;
	logic        dual_bank_q;

	// input stage
	logic        valid_s1;
	logic        action_s1;
	logic [23:0] offset_s1;
	logic [23:0] byte_count_s1;
	logic [31:0] data_word_s1;
	logic        bank_busy_s1;
	logic        security_on_s1;

	// operation state
	phase_t      phase_q, phase_d;
	logic [31:0] addr_q, addr_d;
	logic [23:0] rem_q, rem_d;
	logic        bank_q, bank_d;

	// step results
	cmd_flags_t  flags;
	logic        done;
	logic [31:0] target;
	logic [31:0] wdata;

	// result stage
	logic        valid_s2;
	cmd_flags_t  flags_s2;
	logic        done_s2;
	logic [31:0] target_s2;
	logic [31:0] wdata_s2;

	logic        advance;
	logic [31:0] start_addr;
	logic [23:0] page;
	logic        rem_zero;

	// a step is taken when the result register is free or being drained
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_addr_q     <= BASE_ADDR_RST;
			bank_zero_end_q <= BANK_ZERO_END_RST;
			dual_bank_q     <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_BASE_ADDR:     base_addr_q     <= cfg_data;
				CFG_BANK_ZERO_END: bank_zero_end_q <= cfg_data;
				CFG_DUAL_BANK:     dual_bank_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			action_s1      <= s_tuser;
			offset_s1      <= s_tdata[23:0];
			byte_count_s1  <= s_tdata[47:24];
			data_word_s1   <= s_tdata[79:48];
			bank_busy_s1   <= s_tdata[80];
			security_on_s1 <= s_tdata[81];
		end
	end

	assign start_addr = base_addr_q + {8'd0, offset_s1};
	assign page       = bank_q ? PAGE_BANK_ONE : PAGE_BANK_ZERO;
	assign rem_zero   = (rem_q == 24'd0);

	// next state
	always_comb begin
		phase_d = phase_q;
		addr_d  = addr_q;
		rem_d   = rem_q;
		bank_d  = bank_q;
		unique case (phase_q)
			PH_ERASE_WAIT: begin
				if (action_s1 == ACT_ERASE) begin
					if (!bank_busy_s1)
						phase_d = rem_zero ? PH_IDLE : PH_ERASE_CMD;
				end else begin
					phase_d = PH_IDLE;
				end
			end
			PH_ERASE_CMD: begin
				if (action_s1 == ACT_ERASE) begin
					if (!rem_zero) begin
						// saturate at zero on the last page
						rem_d  = (rem_q > page) ? rem_q - page : 24'd0;
						addr_d = addr_q + {8'd0, page};
					end
					phase_d = PH_ERASE_WAIT;
				end else begin
					phase_d = PH_IDLE;
				end
			end
			PH_WRITE_WAIT: begin
				if (action_s1 == ACT_WRITE) begin
					if (!bank_busy_s1)
						phase_d = rem_zero ? PH_IDLE : PH_WRITE_CMD;
				end else begin
					phase_d = PH_IDLE;
				end
			end
			PH_WRITE_CMD: begin
				if (action_s1 == ACT_WRITE) begin
					if (rem_q >= WORD_BYTES) begin
						addr_d = addr_q + {8'd0, WORD_BYTES};
						rem_d  = rem_q - WORD_BYTES;
					end else begin
						// short tail: one word and done
						rem_d = 24'd0;
					end
					phase_d = PH_WRITE_WAIT;
				end else begin
					phase_d = PH_IDLE;
				end
			end
			default: begin
				addr_d  = start_addr;
				rem_d   = byte_count_s1;
				bank_d  = dual_bank_q && (start_addr >= bank_zero_end_q);
				phase_d = (action_s1 == ACT_WRITE) ? PH_WRITE_WAIT : PH_ERASE_WAIT;
			end
		endcase
	end

	// step outputs
	always_comb begin
		flags  = '0;
		done   = 1'b0;
		target = 32'd0;
		wdata  = 32'd0;
		unique case (phase_q)
			PH_ERASE_WAIT: begin
				if (action_s1 == ACT_ERASE) begin
					if (!bank_busy_s1) begin
						flags.clear_erase_enable = 1'b1;
						flags.do_lock            = rem_zero;
						done                     = rem_zero;
					end
				end else begin
					flags.clear_erase_enable = 1'b1;
				end
			end
			PH_ERASE_CMD: begin
				if (action_s1 == ACT_ERASE && !rem_zero) begin
					flags.start_page_erase = 1'b1;
					flags.mirror_address   = bank_q && security_on_s1;
					target                 = addr_q;
				end
			end
			PH_WRITE_WAIT: begin
				if (action_s1 == ACT_WRITE) begin
					if (!bank_busy_s1) begin
						flags.clear_program_enable = 1'b1;
						flags.do_lock              = rem_zero;
						done                       = rem_zero;
					end
				end else begin
					flags.clear_program_enable = 1'b1;
				end
			end
			PH_WRITE_CMD: begin
				if (action_s1 == ACT_WRITE && !rem_zero) begin
					flags.program_word = 1'b1;
					target             = addr_q;
					wdata              = data_word_s1;
				end
			end
			default: begin
				flags.do_unlock = 1'b1;
			end
		endcase
		flags.use_bank_one = bank_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			addr_q  <= 32'd0;
			rem_q   <= 24'd0;
			bank_q  <= 1'b0;
		end else if (advance) begin
			phase_q <= phase_d;
			addr_q  <= addr_d;
			rem_q   <= rem_d;
			bank_q  <= bank_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			flags_s2  <= flags;
			done_s2   <= done;
			target_s2 <= target;
			wdata_s2  <= wdata;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {wdata_s2, target_s2, flags_s2};
	assign m_tlast  = done_s2;

	// checks
	`ASSERT_IMPLY(a_one_command, valid_s2, $onehot0({flags_s2.do_unlock, flags_s2.do_lock,
		flags_s2.start_page_erase, flags_s2.program_word}), "more than one command in a result")
	`ASSERT_IMPLY(a_mirror_bank_one, valid_s2 && flags_s2.mirror_address,
		flags_s2.start_page_erase && flags_s2.use_bank_one, "mirror without bank one erase")
	`ASSERT_IMPLY(a_done_locks, valid_s2 && done_s2, flags_s2.do_lock, "done without relock")
	`ASSERT_IMPLY(a_target_idle, valid_s2 && !flags_s2.start_page_erase
		&& !flags_s2.program_word, target_s2 == 32'd0, "address with no command")
	`ASSERT_NEXT(a_state_holds, !advance, $stable(phase_q) && $stable(rem_q),
		"state moved without a step")

endmodule

`default_nettype wire

// File: bench/tb_flash_erase_program_sequencer_top.sv
// Self-checking bench for flash_erase_program_sequencer_top: a scoreboard class predicts
// every result item from the accepted step items; plain tasks drive steps and register writes.
// Depends on feps_pkg and the RTL of the sequencer; reads no files.
`timescale 1ns / 1ps

module tb_flash_erase_program_sequencer_top;
	import feps_pkg::*;

	// one step item as the bench sees it, before packing onto s_tdata/s_tuser
	typedef struct {
		logic        act;
		logic [23:0] offset;
		logic [23:0] byte_count;
		logic [31:0] data_word;
		logic        busy;
		logic        secure;
	} flash_step_t;

	// one expected result item
	typedef struct packed {
		logic        done;
		cmd_flags_t  flags;
		logic [31:0] addr;
		logic [31:0] wdata;
	} cmd_result_t;

	// Sequencer predictor plus queue of expected command items.
	class feps_scoreboard;
		phase_t      ph;
		logic [31:0] cur_addr;
		logic [23:0] rem_bytes;
		logic        bank_one;
		logic [31:0] base_addr;
		logic [31:0] zero_end;
		logic        dual;
		cmd_result_t pending[$];
		int          errors;
		int          n_results;
		int          n_done;
		int          n_mirror;

		function new();
			ph = PH_IDLE;
			cur_addr = '0;
			rem_bytes = '0;
			bank_one = 1'b0;
			base_addr = BASE_ADDR_RST;
			zero_end = BANK_ZERO_END_RST;
			dual = 1'b0;
			errors = 0;
			n_results = 0;
			n_done = 0;
			n_mirror = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
			case (idx)
				CFG_BASE_ADDR:     base_addr = val;
				CFG_BANK_ZERO_END: zero_end = val;
				CFG_DUAL_BANK:     dual = val[0];
				default: ;
			endcase
		endfunction

		// advance the predicted sequencer by one accepted step
		function void note_step(flash_step_t st);
			cmd_result_t r;
			logic [23:0] page;
			r = '0;
			if (ph == PH_IDLE) begin
				cur_addr = base_addr + {8'h00, st.offset};
				rem_bytes = st.byte_count;
				bank_one = dual && (cur_addr >= zero_end);
				ph = (st.act == ACT_WRITE) ? PH_WRITE_WAIT : PH_ERASE_WAIT;
				r.flags.do_unlock = 1'b1;
			end else if (st.act == ACT_ERASE) begin
				case (ph)
					PH_ERASE_WAIT: begin
						if (!st.busy) begin
							r.flags.clear_erase_enable = 1'b1;
							if (rem_bytes == '0) begin
								r.flags.do_lock = 1'b1;
								r.done = 1'b1;
								ph = PH_IDLE;
								n_done++;
							end else begin
								ph = PH_ERASE_CMD;
							end
						end
					end
					PH_ERASE_CMD: begin
						if (rem_bytes != '0) begin
							page = bank_one ? PAGE_BANK_ONE : PAGE_BANK_ZERO;
							r.flags.start_page_erase = 1'b1;
							r.flags.mirror_address = bank_one && st.secure;
							r.addr = cur_addr;
							rem_bytes = (rem_bytes > page) ? rem_bytes - page : '0;
							cur_addr = cur_addr + {8'h00, page};
						end
						ph = PH_ERASE_WAIT;
					end
					default: begin
						// erase item during a write: abort
						r.flags.clear_program_enable = (ph == PH_WRITE_WAIT);
						ph = PH_IDLE;
					end
				endcase
			end else begin
				case (ph)
					PH_WRITE_WAIT: begin
						if (!st.busy) begin
							r.flags.clear_program_enable = 1'b1;
							if (rem_bytes == '0) begin
								r.flags.do_lock = 1'b1;
								r.done = 1'b1;
								ph = PH_IDLE;
								n_done++;
							end else begin
								ph = PH_WRITE_CMD;
							end
						end
					end
					PH_WRITE_CMD: begin
						if (rem_bytes != '0) begin
							r.flags.program_word = 1'b1;
							r.addr = cur_addr;
							r.wdata = st.data_word;
							// short tail: one full word, then nothing left
							if (rem_bytes >= WORD_BYTES) begin
								cur_addr = cur_addr + {8'h00, WORD_BYTES};
								rem_bytes = rem_bytes - WORD_BYTES;
							end else begin
								rem_bytes = '0;
							end
						end
						ph = PH_WRITE_WAIT;
					end
					default: begin
						// write item during an erase: abort
						r.flags.clear_erase_enable = (ph == PH_ERASE_WAIT);
						ph = PH_IDLE;
					end
				endcase
			end
			r.flags.use_bank_one = bank_one;
			if (r.flags.mirror_address)
				n_mirror++;
			pending.push_back(r);
		endfunction

		function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(logic [M_TDATA_W-1:0] tdata, logic tlast);
			cmd_result_t e;
			cmd_flags_t  f;
			f = tdata[7:0];
			if (pending.size() == 0) begin
				$error("result item with no step waiting");
				errors++;
				return;
			end
			e = pending.pop_front();
			n_results++;
			cmp_field("done_res", e.done, tlast);
			cmp_field("use_bank_one", e.flags.use_bank_one, f.use_bank_one);
			cmp_field("do_unlock", e.flags.do_unlock, f.do_unlock);
			cmp_field("do_lock", e.flags.do_lock, f.do_lock);
			cmp_field("clear_erase_enable", e.flags.clear_erase_enable, f.clear_erase_enable);
			cmp_field("clear_program_enable", e.flags.clear_program_enable,
				f.clear_program_enable);
			cmp_field("start_page_erase", e.flags.start_page_erase, f.start_page_erase);
			cmp_field("mirror_address", e.flags.mirror_address, f.mirror_address);
			cmp_field("program_word", e.flags.program_word, f.program_word);
			cmp_field("target_address", e.addr, tdata[39:8]);
			cmp_field("write_data", e.wdata, tdata[71:40]);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0] cfg_data;
	logic s_tvalid;
	logic s_tready;
	// offset[23:0], byte_count[47:24], data_word[79:48], bank_busy[80],
	// security_on[81], zero pad[87:82]
	logic [S_TDATA_W-1:0] s_tdata;
	// action[0]
	logic s_tuser;
	logic m_tvalid;
	logic m_tready = 1'b0;
	// use_bank_one[0], do_unlock[1], do_lock[2], clear_erase_enable[3],
	// clear_program_enable[4], start_page_erase[5], mirror_address[6],
	// program_word[7], target_address[39:8], write_data[71:40]
	logic [M_TDATA_W-1:0] m_tdata;
	// done_res
	logic m_tlast;

	feps_scoreboard sb;
	logic steady = 1'b0;	// set: neither side idles
	int n_steps = 0;
	int n_settings = 0;

	flash_erase_program_sequencer_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result side: stall with a chance of about 8 in a hundred unless in the steady stretch
	always @(posedge clk)
		m_tready <= steady || ($urandom_range(99) >= 8);

	// every accepted result item is checked against the oldest prediction
	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tlast);

	function automatic flash_step_t mk(logic act, logic [23:0] off, logic [23:0] cnt,
			logic [31:0] data, logic busy, logic sec);
		flash_step_t st;
		st.act = act;
		st.offset = off;
		st.byte_count = cnt;
		st.data_word = data;
		st.busy = busy;
		st.secure = sec;
		return st;
	endfunction

	function automatic flash_step_t rand_step(logic act);
		return mk(act, 24'($urandom), 24'($urandom), $urandom, 1'($urandom),
			1'($urandom));
	endfunction

	// start offsets: anywhere, around the bank split, low, or at the top of the range
	function automatic logic [23:0] pick_offset();
		logic [31:0] split;
		logic [23:0] d;
		split = sb.zero_end - sb.base_addr;
		d = 24'($urandom_range(0, 16));
		case ($urandom_range(3))
			0: return 24'($urandom);
			1: return split[23:0] + d - 24'd8;
			2: return 24'($urandom_range(0, 256) * 4);
			default: return 24'hFF_FFFF - d;
		endcase
	endfunction

	// lengths around the page and word edges; full-range ones get cut by an abort
	function automatic logic [23:0] pick_count(logic act);
		if (act == ACT_ERASE) begin
			case ($urandom_range(7))
				0: return '0;
				1: return 24'($urandom_range(1, 2047));
				2: return 24'd2048;
				3: return 24'd2049;
				4: return 24'd4096;
				5: return 24'd4097;
				6: return 24'($urandom_range(0, 12000));
				default: return 24'($urandom);
			endcase
		end
		case ($urandom_range(7))
			0: return '0;
			1: return 24'($urandom_range(1, 3));
			2: return 24'd4;
			3: return 24'($urandom_range(5, 12));
			4, 5: return 24'($urandom_range(0, 48));
			6: return 24'($urandom_range(0, 200));
			default: return 24'($urandom);
		endcase
	endfunction

	// present one item, hold it until taken, then maybe leave a gap
	task automatic send_step(input flash_step_t st);
		s_tdata <= {6'b0, st.secure, st.busy, st.data_word, st.byte_count, st.offset};
		s_tuser <= st.act;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_step(st);
		n_steps++;
		if (!steady && $urandom_range(99) < 8) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	// all three registers on consecutive edges; only called with nothing in flight
	task automatic set_config(input logic [31:0] base, input logic [31:0] zend,
			input logic dual);
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_BASE_ADDR;
		cfg_data <= base;
		@(posedge clk);
		cfg_index <= CFG_BANK_ZERO_END;
		cfg_data <= zend;
		@(posedge clk);
		cfg_index <= CFG_DUAL_BANK;
		cfg_data <= {31'b0, dual};
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.write_reg(CFG_BASE_ADDR, base);
		sb.write_reg(CFG_BANK_ZERO_END, zend);
		sb.write_reg(CFG_DUAL_BANK, {31'b0, dual});
		n_settings++;
	endtask

	// one operation: start, then wait/command steps with random busy until done,
	// unless cut short, in which case an item of the other kind aborts it
	task automatic run_op(input logic act);
		flash_step_t st;
		int cap;
		int k;
		st = rand_step(act);
		st.offset = pick_offset();
		st.byte_count = pick_count(act);
		send_step(st);
		cap = ($urandom_range(99) < 12) ? $urandom_range(1, 6) : 120;
		k = 0;
		while (sb.ph != PH_IDLE && k < cap) begin
			st = rand_step(act);
			st.busy = ($urandom_range(99) < 20);
			send_step(st);
			k++;
		end
		if (sb.ph != PH_IDLE)
			send_step(rand_step(~act));
	endtask

	// leave the sequencer idle and the pipeline empty before a register write
	task automatic settle();
		if (sb.ph == PH_ERASE_WAIT || sb.ph == PH_ERASE_CMD)
			send_step(rand_step(ACT_WRITE));
		else if (sb.ph != PH_IDLE)
			send_step(rand_step(ACT_ERASE));
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic random_phase(input logic [31:0] base, input logic [31:0] zend,
			input logic dual, input int n_items);
		int stop_at;
		set_config(base, zend, dual);
		stop_at = n_steps + n_items;
		while (n_steps < stop_at) begin
			if ($urandom_range(99) < 6)
				send_step(rand_step(1'($urandom)));	// noise, may break a sequence
			else
				run_op(1'($urandom));
		end
		settle();
	endtask

	initial begin
		sb = new();
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= ACT_ERASE;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: split at 0x80000 into the flash, bank one enabled
		set_config(BASE_ADDR_RST, BANK_ZERO_END_RST, 1'b1);
		// zero length erase: unlock, then straight to relock and done
		send_step(mk(ACT_ERASE, 24'h0, 24'h0, 32'h0, 1'b0, 1'b0));
		send_step(mk(ACT_ERASE, 24'h0, 24'h0, 32'h0, 1'b0, 1'b0));
		// last bank-zero page, 2049 bytes: busy hold, two pages, length saturates
		send_step(mk(ACT_ERASE, 24'h07_F800, 24'd2049, 32'h0, 1'b0, 1'b0));
		send_step(mk(ACT_ERASE, 24'h0, 24'h0, 32'h0, 1'b1, 1'b0));
		send_step(mk(ACT_ERASE, 24'h0, 24'h0, 32'h0, 1'b0, 1'b0));
		send_step(mk(ACT_ERASE, 24'h0, 24'h0, 32'h0, 1'b0, 1'b1));
		send_step(mk(ACT_ERASE, 24'h0, 24'h0, 32'h0, 1'b0, 1'b0));
		send_step(mk(ACT_ERASE, 24'h0, 24'h0, 32'h0, 1'b0, 1'b0));
		send_step(mk(ACT_ERASE, 24'h0, 24'h0, 32'h0, 1'b0, 1'b0));
		// first bank-one page with security on: mirrored address
		send_step(mk(ACT_ERASE, 24'h08_0000, 24'd4096, 32'h0, 1'b0, 1'b0));
		send_step(mk(ACT_ERASE, 24'h0, 24'h0, 32'h0, 1'b0, 1'b0));
		send_step(mk(ACT_ERASE, 24'h0, 24'h0, 32'h0, 1'b0, 1'b1));
		send_step(mk(ACT_ERASE, 24'h0, 24'h0, 32'h0, 1'b0, 1'b0));
		// 5 byte write at the top offset: one word, then a short tail
		send_step(mk(ACT_WRITE, 24'hFF_FFFC, 24'd5, 32'h0, 1'b0, 1'b0));
		send_step(mk(ACT_WRITE, 24'h0, 24'h0, 32'h0, 1'b0, 1'b0));
		send_step(mk(ACT_WRITE, 24'h0, 24'h0, 32'hFFFF_FFFF, 1'b0, 1'b0));
		send_step(mk(ACT_WRITE, 24'h0, 24'h0, 32'h0, 1'b0, 1'b0));
		send_step(mk(ACT_WRITE, 24'h0, 24'h0, 32'h0, 1'b0, 1'b0));
		send_step(mk(ACT_WRITE, 24'h0, 24'h0, 32'h0, 1'b0, 1'b0));
		// aborts: erase item in write wait, write item in erase command
		send_step(mk(ACT_WRITE, 24'h0, 24'd8, 32'h0, 1'b0, 1'b0));
		send_step(mk(ACT_ERASE, 24'h0, 24'h0, 32'h0, 1'b0, 1'b0));
		send_step(mk(ACT_ERASE, 24'h0, 24'd1, 32'h0, 1'b0, 1'b0));
		send_step(mk(ACT_ERASE, 24'h0, 24'h0, 32'h0, 1'b0, 1'b0));
		send_step(mk(ACT_WRITE, 24'h0, 24'h0, 32'h0, 1'b0, 1'b0));
		// all fields at their maximum, then a write item aborts in erase wait
		send_step(mk(ACT_ERASE, 24'hFF_FFFF, 24'hFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1));
		send_step(mk(ACT_WRITE, 24'hFF_FFFF, 24'hFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1));
		settle();

		// random phases over several register settings, extremes included
		random_phase(BASE_ADDR_RST, BANK_ZERO_END_RST, 1'b0, 260);
		random_phase(BASE_ADDR_RST, BANK_ZERO_END_RST, 1'b1, 260);
		steady = 1'b1;
		random_phase(32'h0, 32'h0, 1'b1, 260);
		steady = 1'b0;
		random_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 260);
		random_phase(32'h0, 32'hFFFF_FFFF, 1'b1, 250);
		random_phase($urandom, $urandom, 1'($urandom), 250);
		random_phase($urandom, $urandom, 1'b1, 250);

		$display("Run covered %0d step items under %0d register settings:",
			n_steps, n_settings);
		$display("%0d results, %0d operations done, %0d mirrored erases.",
			sb.n_results, sb.n_done, sb.n_mirror);
		if (sb.errors == 0)
			$display("[flash_erase_program_sequencer_top] OK");
		else
			$display("[flash_erase_program_sequencer_top] ERROR");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("[flash_erase_program_sequencer_top] ERROR");
		$finish;
	end

endmodule
